[rtl/core/agc_polyphase_resampler_assert.svh]
// Assertion macros for the resampler core.
`ifndef AGC_POLYPHASE_RESAMPLER_ASSERT_SVH
`define AGC_POLYPHASE_RESAMPLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AGCR_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("resampler assertion failed");

// Next-cycle implication, checked outside reset.
`define AGCR_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("resampler assertion failed");

`endif

[rtl/core/agcr_pkg.sv]
package agcr_pkg;

    localparam int HIST_TAPS      = 120;
    localparam int INTERP_PHASES  = 4;
    localparam int DECIM_STEP     = 15;
    localparam int SUBBLOCK_SIZE  = 512;

    localparam int TAP_W   = $clog2(HIST_TAPS);
    localparam int PHASE_W = $clog2(INTERP_PHASES);
    localparam int GAP_W   = $clog2(DECIM_STEP + 1);
    localparam int FILL_W  = $clog2(SUBBLOCK_SIZE);
    localparam int COEF_W  = 24;
    localparam int ACC_W   = 16 + COEF_W + TAP_W + 1;
    localparam int DIV_W   = 47;
    localparam int DIVC_W  = $clog2(DIV_W + 1);

    localparam logic [14:0] TARGET_RST  = 15'd8000;
    localparam logic [14:0] FLOOR_RST   = 15'd50;
    localparam logic [23:0] RELEASE_RST = 24'd16776377;

    typedef enum logic [1:0] {
        REG_TARGET  = 2'd0,
        REG_FLOOR   = 2'd1,
        REG_RELEASE = 2'd2
    } t_reg_idx;

    localparam longint K  = 64'sd8388608;
    localparam longint D1 = 64'sd10000000000;
    localparam longint D2 = 64'sd100000000000;
    localparam longint D3 = 64'sd1000000000000;
    localparam longint D4 = 64'sd10000000000000;
    localparam longint D5 = 64'sd100000000000000;
    localparam longint D6 = 64'sd1000000000000000;
    localparam longint D7 = 64'sd10000000000000000;
    localparam longint D8 = 64'sd100000000000000000;

    localparam longint ROM0 [HIST_TAPS] = '{
        64'sd0, -((64'sd1084814782*K+D6/2)/D6), -((64'sd5352920494*K+D6/2)/D6),
        -((64'sd6295617728*K+D6/2)/D6),
        (64'sd7088871390*K+D6/2)/D6, (64'sd3362889998*K+D5/2)/D5,
        (64'sd4983366585*K+D5/2)/D5, (64'sd2365648799*K+D5/2)/D5,
        -((64'sd5163992772*K+D5/2)/D5), -((64'sd1322862573*K+D4/2)/D4),
        -((64'sd1399712912*K+D4/2)/D4), -((64'sd2270712728*K+D5/2)/D5),
        (64'sd1797295117*K+D4/2)/D4, (64'sd3278819889*K+D4/2)/D4,
        (64'sd2649130918*K+D4/2)/D4, -((64'sd4950188372*K+D5/2)/D5),
        -((64'sd4545458974*K+D4/2)/D4), -((64'sd6473114721*K+D4/2)/D4),
        -((64'sd3872259492*K+D4/2)/D4), (64'sd2784459909*K+D4/2)/D4,
        (64'sd9527252062*K+D4/2)/D4, (64'sd1097391389*K+D3/2)/D3,
        (64'sd4256912039*K+D4/2)/D4, -((64'sd7866833146*K+D4/2)/D4),
        -((64'sd1751138692*K+D3/2)/D3), -((64'sd1642276898*K+D3/2)/D3),
        -((64'sd2398219103*K+D4/2)/D4), (64'sd1729901949*K+D3/2)/D3,
        (64'sd2905016359*K+D3/2)/D3, (64'sd2178536883*K+D3/2)/D3,
        -((64'sd3804902075*K+D4/2)/D4), -((64'sd3285113929*K+D3/2)/D3),
        -((64'sd4421689274*K+D3/2)/D3), -((64'sd2511481456*K+D3/2)/D3),
        (64'sd1721798711*K+D3/2)/D3, (64'sd5637867228*K+D3/2)/D3,
        (64'sd6236314034*K+D3/2)/D3, (64'sd2330826887*K+D3/2)/D3,
        -((64'sd4163305937*K+D3/2)/D3), -((64'sd8985162006*K+D3/2)/D3),
        -((64'sd8195137404*K+D3/2)/D3), -((64'sd1167501993*K+D3/2)/D3),
        (64'sd8242228285*K+D3/2)/D3, (64'sd1359216824*K+D2/2)/D2,
        (64'sd1004573047*K+D2/2)/D2, -((64'sd1735912350*K+D3/2)/D3),
        -((64'sd1489252757*K+D2/2)/D2), -((64'sd2001404094*K+D2/2)/D2),
        -((64'sd1141299733*K+D2/2)/D2), (64'sd7906139454*K+D3/2)/D3,
        (64'sd2635872143*K+D2/2)/D2, (64'sd2996356232*K+D2/2)/D2,
        (64'sd1164265242*K+D2/2)/D2, -((64'sd2194324403*K+D2/2)/D2),
        -((64'sd5096643955*K+D2/2)/D2), -((64'sd5142342106*K+D2/2)/D2),
        -((64'sd8441918558*K+D3/2)/D3), (64'sd7339480894*K+D2/2)/D2,
        (64'sd1690913211*K+D1/2)/D1, (64'sd2432057709*K+D1/2)/D1,
        (64'sd2661725457*K+D1/2)/D1, (64'sd2285762065*K+D1/2)/D1,
        (64'sd1457731651*K+D1/2)/D1, (64'sd5037048049*K+D2/2)/D2,
        -((64'sd2339129215*K+D2/2)/D2), -((64'sd5507882147*K+D2/2)/D2),
        -((64'sd4550238496*K+D2/2)/D2), -((64'sd1303389039*K+D2/2)/D2),
        (64'sd1817561525*K+D2/2)/D2, (64'sd3104368171*K+D2/2)/D2,
        (64'sd2263652821*K+D2/2)/D2, (64'sd2597799630*K+D3/2)/D3,
        -((64'sd1485572071*K+D2/2)/D2), -((64'sd1992133995*K+D2/2)/D2),
        -((64'sd1200169618*K+D2/2)/D2), (64'sd1692384217*K+D3/2)/D3,
        (64'sd1184627188*K+D2/2)/D2, (64'sd1297095558*K+D2/2)/D2,
        (64'sd6009795901*K+D3/2)/D3, -((64'sd3368192834*K+D3/2)/D3),
        -((64'sd9030659752*K+D3/2)/D3), -((64'sd8188595697*K+D3/2)/D3),
        -((64'sd2510421177*K+D3/2)/D3), (64'sd3678794056*K+D3/2)/D3,
        (64'sd6511750747*K+D3/2)/D3, (64'sd4867467725*K+D3/2)/D3,
        (64'sd5675958453*K+D4/2)/D4, -((64'sd3274152790*K+D3/2)/D3),
        -((64'sd4401650078*K+D3/2)/D3), -((64'sd2644353206*K+D3/2)/D3),
        (64'sd3701040762*K+D4/2)/D4, (64'sd2560571731*K+D3/2)/D3,
        (64'sd2760596488*K+D3/2)/D3, (64'sd1254972446*K+D3/2)/D3,
        -((64'sd6878150899*K+D4/2)/D4), -((64'sd1797676994*K+D3/2)/D3),
        -((64'sd1584057895*K+D3/2)/D3), -((64'sd4704795200*K+D4/2)/D4),
        (64'sd6658599682*K+D4/2)/D4, (64'sd1134678810*K+D3/2)/D3,
        (64'sd8138196519*K+D4/2)/D4, (64'sd9073501585*K+D5/2)/D5,
        -((64'sd4985175818*K+D4/2)/D4), -((64'sd6356407082*K+D4/2)/D4),
        -((64'sd3604809845*K+D4/2)/D4), (64'sd4737238901*K+D5/2)/D5,
        (64'sd3058347823*K+D4/2)/D4, (64'sd3054517631*K+D4/2)/D4,
        (64'sd1275244062*K+D4/2)/D4, -((64'sd6351451720*K+D5/2)/D5),
        -((64'sd1489009898*K+D4/2)/D4), -((64'sd1157735450*K+D4/2)/D4),
        -((64'sd2970538246*K+D5/2)/D5), (64'sd3531453756*K+D5/2)/D5,
        (64'sd4864500419*K+D5/2)/D5, (64'sd2669385367*K+D5/2)/D5,
        (64'sd2094219199*K+D6/2)/D6, -((64'sd7038615552*K+D6/2)/D6),
        -((64'sd4168009843*K+D6/2)/D6), -((64'sd5023455431*K+D7/2)/D7)
    };

    localparam longint ROM1 [HIST_TAPS] = '{
        -((64'sd2554809599*K+D8/2)/D8), -((64'sd1923261847*K+D6/2)/D6),
        -((64'sd6361449877*K+D6/2)/D6), -((64'sd4593557782*K+D6/2)/D6),
        (64'sd1303256191*K+D5/2)/D5, (64'sd3997574821*K+D5/2)/D5,
        (64'sd4824496707*K+D5/2)/D5, (64'sd8652212259*K+D6/2)/D6,
        -((64'sd7411158285*K+D5/2)/D5), -((64'sd1441161630*K+D4/2)/D4),
        -((64'sd1227441761*K+D4/2)/D4), (64'sd2397642027*K+D5/2)/D5,
        (64'sd2286674379*K+D4/2)/D4, (64'sd3365164325*K+D4/2)/D4,
        (64'sd2071912714*K+D4/2)/D4, -((64'sd1528423985*K+D4/2)/D4),
        -((64'sd5350603327*K+D4/2)/D4), -((64'sd6291603712*K+D4/2)/D4),
        -((64'sd2486819775*K+D4/2)/D4), (64'sd4675243178*K+D4/2)/D4,
        (64'sd1057252392*K+D3/2)/D3, (64'sd1006079763*K+D3/2)/D3,
        (64'sd1489142191*K+D4/2)/D4, -((64'sd1087703462*K+D3/2)/D3),
        -((64'sd1847978290*K+D3/2)/D3), -((64'sd1400938203*K+D3/2)/D3),
        (64'sd2471564906*K+D4/2)/D4, (64'sd2153964417*K+D3/2)/D3,
        (64'sd2924369566*K+D3/2)/D3, (64'sd1674299314*K+D3/2)/D3,
        -((64'sd1156245927*K+D3/2)/D3), -((64'sd3811109046*K+D3/2)/D3),
        -((64'sd4240639613*K+D3/2)/D3), -((64'sd1593192467*K+D3/2)/D3),
        (64'sd2858409288*K+D3/2)/D3, (64'sd6191452975*K+D3/2)/D3,
        (64'sd5662779658*K+D3/2)/D3, (64'sd8082208384*K+D4/2)/D4,
        -((64'sd5710383803*K+D3/2)/D3), -((64'sd9413534167*K+D3/2)/D3),
        -((64'sd6945690158*K+D3/2)/D3), (64'sd1196386233*K+D3/2)/D3,
        (64'sd1021293493*K+D2/2)/D2, (64'sd1362827311*K+D2/2)/D2,
        (64'sd7697098706*K+D3/2)/D3, -((64'sd5264535961*K+D3/2)/D3),
        -((64'sd1726214485*K+D2/2)/D2), -((64'sd1920307008*K+D2/2)/D2),
        -((64'sd7254151722*K+D3/2)/D3), (64'sd1317432738*K+D2/2)/D2,
        (64'sd2911758124*K+D2/2)/D2, (64'sd2744080765*K+D2/2)/D2,
        (64'sd4085353855*K+D3/2)/D3, -((64'sd3059095690*K+D2/2)/D2),
        -((64'sd5459851135*K+D2/2)/D2), -((64'sd4495156692*K+D2/2)/D2),
        (64'sd9043274377*K+D3/2)/D3, (64'sd9734089707*K+D2/2)/D2,
        (64'sd1910305042*K+D1/2)/D1, (64'sd2545334483*K+D1/2)/D1,
        (64'sd2622578678*K+D1/2)/D1, (64'sd2110313228*K+D1/2)/D1,
        (64'sd1216597224*K+D1/2)/D1, (64'sd2877179758*K+D2/2)/D2,
        -((64'sd3559947218*K+D2/2)/D2), -((64'sd5606382902*K+D2/2)/D2),
        -((64'sd3857870672*K+D2/2)/D2), -((64'sd4241892100*K+D3/2)/D3),
        (64'sd2348702480*K+D2/2)/D2, (64'sd3072820061*K+D2/2)/D2,
        (64'sd1816444258*K+D2/2)/D2, -((64'sd2524350181*K+D3/2)/D3),
        -((64'sd1747484194*K+D2/2)/D2), -((64'sd1897592755*K+D2/2)/D2),
        -((64'sd8739616072*K+D3/2)/D3), (64'sd4878309904*K+D3/2)/D3,
        (64'sd1304799999*K+D2/2)/D2, (64'sd1181952704*K+D2/2)/D2,
        (64'sd3624437512*K+D3/2)/D3, -((64'sd5318377187*K+D3/2)/D3),
        -((64'sd9435807326*K+D3/2)/D3), -((64'sd7075901711*K+D3/2)/D3),
        -((64'sd8284666761*K+D4/2)/D4), (64'sd4802068104*K+D3/2)/D3,
        (64'sd6491682840*K+D3/2)/D3, (64'sd3924460952*K+D3/2)/D3,
        -((64'sd5530973588*K+D4/2)/D4), -((64'sd3855906663*K+D3/2)/D3),
        -((64'sd4191789279*K+D3/2)/D3), -((64'sd1922814251*K+D3/2)/D3),
        (64'sd1064118853*K+D3/2)/D3, (64'sd2810398050*K+D3/2)/D3,
        (64'sd2504416608*K+D3/2)/D3, (64'sd7528745903*K+D4/2)/D4,
        -((64'sd1079471316*K+D3/2)/D3), -((64'sd1865473774*K+D3/2)/D3),
        -((64'sd1358397764*K+D3/2)/D3), -((64'sd1539633985*K+D4/2)/D4),
        (64'sd8612159134*K+D4/2)/D4, (64'sd1119911556*K+D3/2)/D3,
        (64'sd6490547677*K+D4/2)/D4, -((64'sd8737970318*K+D5/2)/D5),
        -((64'sd5796167215*K+D4/2)/D4), -((64'sd5969514983*K+D4/2)/D4),
        -((64'sd2581610400*K+D4/2)/D4), (64'sd1339513587*K+D4/2)/D4,
        (64'sd3295584537*K+D4/2)/D4, (64'sd2715077913*K+D4/2)/D4,
        (64'sd7477530689*K+D5/2)/D5, -((64'sd9713788811*K+D5/2)/D5),
        -((64'sd1500118065*K+D4/2)/D4), -((64'sd9592656802*K+D5/2)/D5),
        -((64'sd9333971878*K+D6/2)/D6), (64'sd4348780400*K+D5/2)/D5,
        (64'sd4517357264*K+D5/2)/D5, (64'sd1968257613*K+D5/2)/D5,
        -((64'sd1813025753*K+D6/2)/D6), -((64'sd6993483109*K+D6/2)/D6),
        -((64'sd2980071999*K+D6/2)/D6), -((64'sd1660779086*K+D7/2)/D7)
    };

    // Phases two and three are the stored phases in reverse tap order.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [PHASE_W-1:0] phase,
        input logic [TAP_W-1:0]   tap
    );
        logic             use_rom1;
        logic             rev;
        logic [TAP_W-1:0] idx;
        use_rom1 = (phase == PHASE_W'(1)) || (phase == PHASE_W'(2));
        rev      = phase[PHASE_W-1];
        idx      = rev ? TAP_W'(HIST_TAPS - 1) - tap : tap;
        if (use_rom1) begin
            coef_at = COEF_W'(ROM1[idx]);
        end else begin
            coef_at = COEF_W'(ROM0[idx]);
        end
    endfunction

endpackage

[rtl/core/agc_polyphase_resampler.sv]
// Each sample request steps through peak update, a serial gain divider, scaling and a
// write into the one-port history memory; when an output is due, a serial MAC over the
// 120 history taps through that memory and the pipeline drain follow before the result.
// The divider is skipped when a zero peak saturates the gain.
// A new request is taken only in idle, so one sample is finished before the next is taken,
// and a finished result waits in its last step until the previous one has been taken.
// Reset restores the register defaults, sets the peak to the default target and clears history, gap and count.
`include "agc_polyphase_resampler_assert.svh"

module agc_polyphase_resampler import agcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [15:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_sample,
    output logic               o_block_last
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PEAK  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_MAC   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [14:0] r_target;
    logic [14:0] r_floor;
    logic [23:0] r_release;

    logic [31:0]        r_peak;
    logic [55:0]        r_dec_prod;
    logic               r_neg;
    logic [16:0]        r_mag;
    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [DIVC_W-1:0]  r_div_cnt;
    logic               r_gain_sat;
    logic [48:0]        r_sc_prod;
    logic [GAP_W-1:0]   r_gap;
    logic [FILL_W-1:0]  r_fill;
    logic [TAP_W-1:0]   r_wptr;
    logic [TAP_W-1:0]   r_raddr;
    logic [TAP_W-1:0]   r_tap;
    logic               r_issuing;
    logic [PHASE_W-1:0] r_phase;

    logic signed [15:0]            mem [HIST_TAPS];
    logic [HIST_TAPS-1:0]          r_hvalid;
    logic signed [15:0]            r_rd_data;
    logic                          r_rd_ok;
    logic signed [COEF_W-1:0]      r_coef;
    logic                          r_v1;
    logic signed [16+COEF_W-1:0]   r_mult;
    logic                          r_v2;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [15:0] r_out_sample;
    logic               r_out_valid;
    logic               r_out_last;

    logic        in_acc;
    logic [31:0] peak_new;
    logic [31:0] pk;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [31:0] gain;
    logic [32:0] sc;
    logic [16:0] sc_lim;
    logic signed [15:0] hist_v;
    logic [TAP_W-1:0]   wptr_nx;
    logic        due;
    logic        mem_we;
    logic [ACC_W-1:0] acc_abs;
    logic [24:0] q;
    logic [15:0] q_lim;
    logic signed [15:0] res;
    logic        out_free;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_block_last = r_out_last;
    assign out_free     = !r_out_valid || i_out_ready;

    always_comb begin
        peak_new = r_dec_prod[55:24];
        if ({r_mag[15:0], 16'b0} > peak_new || r_mag[16]) begin
            peak_new = {r_mag[15:0], 16'b0};
        end
        pk = ({r_floor, 16'b0} > {1'b0, peak_new}) ? {1'b0, r_floor, 16'b0} : peak_new;

        rem_sh = {r_rem, r_quo[DIV_W-1]};
        rem_ge = rem_sh >= {1'b0, r_den};

        gain = (r_gain_sat || (|r_quo[DIV_W-1:32])) ? 32'hFFFF_FFFF : r_quo[31:0];

        sc = r_sc_prod[48:16];
        if (r_neg) begin
            sc_lim = (sc > 33'd32768) ? 17'd32768 : sc[16:0];
        end else begin
            sc_lim = (sc > 33'd32767) ? 17'd32767 : sc[16:0];
        end
        hist_v = r_neg ? 16'(-sc_lim) : 16'(sc_lim);

        wptr_nx = (r_wptr == TAP_W'(HIST_TAPS - 1)) ? '0 : r_wptr + 1'b1;
        due     = r_gap < GAP_W'(INTERP_PHASES);
        mem_we  = (r_state == S_WRITE);

        acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        q       = 25'(acc_abs >> 23);
        if (r_acc[ACC_W-1]) begin
            q_lim = (q > 25'd32768) ? 16'h8000 : q[15:0];
            res   = 16'(-q_lim);
        end else begin
            q_lim = (q > 25'd32767) ? 16'h7FFF : q[15:0];
            res   = q_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wptr_nx] <= hist_v;
        end
        if (r_state == S_MAC && r_issuing) begin
            r_rd_data <= mem[r_raddr];
            r_rd_ok   <= r_hvalid[r_raddr];
            r_coef    <= coef_at(r_phase, r_tap);
        end
        r_mult <= (r_rd_ok ? r_rd_data : 16'sd0) * r_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= TARGET_RST;
            r_floor     <= FLOOR_RST;
            r_release   <= RELEASE_RST;
            r_peak      <= {1'b0, TARGET_RST, 16'b0};
            r_gap       <= '0;
            r_fill      <= '0;
            r_wptr      <= '0;
            r_hvalid    <= '0;
            r_issuing   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TARGET:  r_target  <= i_cfg_data[14:0];
                    REG_FLOOR:   r_floor   <= i_cfg_data[14:0];
                    REG_RELEASE: r_release <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= (r_state == S_MAC) && r_issuing;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_mult);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_action) begin
                            r_peak   <= {1'b0, r_target, 16'b0};
                            r_gap    <= '0;
                            r_fill   <= '0;
                            r_wptr   <= '0;
                            r_hvalid <= '0;
                        end else begin
                            r_neg      <= i_sample[15];
                            r_mag      <= i_sample[15] ? 17'(-{i_sample[15], i_sample})
                                                       : 17'(i_sample);
                            r_dec_prod <= r_peak * r_release;
                            r_state    <= S_PEAK;
                        end
                    end
                end
                S_PEAK: begin
                    r_peak     <= peak_new;
                    r_den      <= pk;
                    r_rem      <= '0;
                    r_quo      <= {r_target, 32'b0};
                    r_div_cnt  <= DIVC_W'(DIV_W);
                    r_gain_sat <= (pk == '0);
                    r_state    <= (pk == '0) ? S_SCALE : S_DIV;
                end
                S_DIV: begin
                    r_rem     <= rem_ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                    r_quo     <= {r_quo[DIV_W-2:0], rem_ge};
                    r_div_cnt <= r_div_cnt - 1'b1;
                    if (r_div_cnt == DIVC_W'(1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_sc_prod <= r_mag * gain;
                    r_state   <= S_WRITE;
                end
                S_WRITE: begin
                    r_wptr           <= wptr_nx;
                    r_hvalid[wptr_nx] <= 1'b1;
                    r_gap <= due ? GAP_W'(r_gap + GAP_W'(DECIM_STEP - INTERP_PHASES))
                                 : GAP_W'(r_gap - GAP_W'(INTERP_PHASES));
                    if (due) begin
                        r_phase   <= r_gap[PHASE_W-1:0];
                        r_raddr   <= wptr_nx;
                        r_tap     <= '0;
                        r_issuing <= 1'b1;
                        r_acc     <= '0;
                        r_state   <= S_MAC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MAC: begin
                    if (r_issuing) begin
                        r_raddr <= (r_raddr == '0) ? TAP_W'(HIST_TAPS - 1)
                                                   : r_raddr - 1'b1;
                        r_tap   <= r_tap + 1'b1;
                        if (r_tap == TAP_W'(HIST_TAPS - 1)) begin
                            r_issuing <= 1'b0;
                        end
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_sample <= res;
                        r_out_valid  <= 1'b1;
                        r_out_last   <= (r_fill == FILL_W'(SUBBLOCK_SIZE - 1));
                        r_fill       <= (r_fill == FILL_W'(SUBBLOCK_SIZE - 1))
                                        ? '0 : r_fill + 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AGCR_ASSERT_NOW(a_gap_range, 1'b1, r_gap < GAP_W'(DECIM_STEP))
    `AGCR_ASSERT_NEXT(a_restart_clears, in_acc && i_action, r_fill == '0 && r_gap == '0)
    `AGCR_ASSERT_NOW(a_last_wraps, r_out_valid && r_out_last && r_state == S_IDLE, r_fill == '0)
    `AGCR_ASSERT_NOW(a_mac_after_fill, r_state == S_MAC, r_hvalid[r_wptr])

endmodule
